[src/crcfpr_pkg.sv]
`default_nettype none
package crcfpr_pkg;

    // Sync pattern
    localparam logic [7:0] SYNC_FIRST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Reset value of the payload limit register
    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd89;

    // Byte positions within a frame
    localparam int unsigned POS_W = 9;
    localparam logic [POS_W-1:0] POS_HUNT  = 9'd0;
    localparam logic [POS_W-1:0] POS_SYNC2 = 9'd1;
    localparam logic [POS_W-1:0] POS_LEN   = 9'd2;
    localparam logic [POS_W-1:0] POS_CMD   = 9'd3;
    localparam logic [POS_W-1:0] POS_SEQ   = 9'd4;
    localparam logic [POS_W-1:0] POS_BODY  = 9'd5;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD_CRC  = 2'd2,
        KIND_TOO_LONG = 2'd3
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [7:0]  frame_command;
        logic [7:0]  frame_sequence;
        logic [7:0]  frame_len;
        logic [15:0] received_check;
        logic [15:0] computed_check;
    } t_result;

endpackage
`default_nettype wire

[src/crcfpr_if.sv]
`default_nettype none
// Received byte channel
interface crcfpr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Result item channel
interface crcfpr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  frame_command;
    logic [7:0]  frame_sequence;
    logic [7:0]  frame_len;
    logic [15:0] received_check;
    logic [15:0] computed_check;

    modport source (
        output valid, output kind, output payload_byte, output payload_index,
        output frame_command, output frame_sequence, output frame_len,
        output received_check, output computed_check, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input payload_index,
        input frame_command, input frame_sequence, input frame_len,
        input received_check, input computed_check, output ready
    );
endinterface
`default_nettype wire

[src/crcfpr_crc16.sv]
`default_nettype none
module crcfpr_crc16 (
    input  wire logic [15:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [15:0] o_crc
);
    import crcfpr_pkg::*;

    // Fold one byte in, MSB first, one shift per bit
    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {i_byte, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (v_crc[15]) begin
                v_crc = {v_crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v_crc = {v_crc[14:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule
`default_nettype wire

[src/crcfpr_parser.sv]
`default_nettype none
module crcfpr_parser (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic [7:0]          i_byte,
    input  wire logic [7:0]          i_max_payload,
    output crcfpr_pkg::t_result      o_res
);
    import crcfpr_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_crc_lo, n_crc_lo;

    logic [POS_W-1:0] w_crc_lo_pos;
    logic [POS_W-1:0] w_crc_hi_pos;
    logic             w_in_body;
    logic             w_in_payload;
    logic             w_at_crc_lo;
    logic             w_at_crc_hi;
    logic             w_hunt;
    logic [15:0]      w_crc_base;
    logic [15:0]      w_crc_fed;
    logic [15:0]      w_rx_check;

    // Decode where the incoming byte falls in the frame
    assign w_crc_lo_pos = POS_BODY + {1'b0, r_len};
    assign w_crc_hi_pos = w_crc_lo_pos + 9'd1;
    assign w_in_body    = (r_pos >= POS_BODY);
    assign w_in_payload = w_in_body && (r_pos < w_crc_lo_pos);
    assign w_at_crc_lo  = w_in_body && (r_pos == w_crc_lo_pos);
    assign w_at_crc_hi  = w_in_body && (r_pos == w_crc_hi_pos);
    assign w_hunt       = (r_pos == POS_HUNT) ||
                          (w_in_body && !w_in_payload && !w_at_crc_lo && !w_at_crc_hi);
    assign w_rx_check   = {i_byte, r_crc_lo};

    // A sync byte restarts the CRC from its initial value
    assign w_crc_base = w_hunt ? CRC_INIT : r_crc;

    crcfpr_crc16 u_crc16 (
        .i_crc  (w_crc_base),
        .i_byte (i_byte),
        .o_crc  (w_crc_fed)
    );

    // Next state and the result caused by this byte
    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_len    = r_len;
        n_cmd    = r_cmd;
        n_seq    = r_seq;
        n_crc_lo = r_crc_lo;

        o_res                = '0;
        o_res.kind           = KIND_PAYLOAD;

        if (r_pos == POS_SYNC2) begin
            if (i_byte == SYNC_SECOND) begin
                n_crc = w_crc_fed;
                n_pos = POS_LEN;
            end else begin
                n_pos = POS_HUNT;
            end
        end else if (r_pos == POS_LEN) begin
            n_len = i_byte;
            n_crc = w_crc_fed;
            n_pos = POS_CMD;
        end else if (r_pos == POS_CMD) begin
            n_cmd = i_byte;
            n_crc = w_crc_fed;
            n_pos = POS_SEQ;
        end else if (r_pos == POS_SEQ) begin
            n_seq = i_byte;
            n_crc = w_crc_fed;
            if (r_len > i_max_payload) begin
                n_pos       = POS_HUNT;
                o_res.valid = 1'b1;
                o_res.kind  = KIND_TOO_LONG;
            end else begin
                n_pos = POS_BODY;
            end
        end else if (w_in_payload) begin
            n_crc               = w_crc_fed;
            n_pos               = r_pos + 9'd1;
            o_res.valid         = 1'b1;
            o_res.kind          = KIND_PAYLOAD;
            o_res.payload_byte  = i_byte;
            o_res.payload_index = 8'(r_pos - POS_BODY);
        end else if (w_at_crc_lo) begin
            n_crc_lo = i_byte;
            n_pos    = r_pos + 9'd1;
        end else if (w_at_crc_hi) begin
            n_pos                = POS_HUNT;
            o_res.valid          = 1'b1;
            o_res.kind           = (w_rx_check == r_crc) ? KIND_GOOD : KIND_BAD_CRC;
            o_res.received_check = w_rx_check;
            o_res.computed_check = r_crc;
        end else begin
            // Hunt: only the first sync byte leaves this position
            n_pos = POS_HUNT;
            if (i_byte == SYNC_FIRST) begin
                n_crc = w_crc_fed;
                n_pos = POS_SYNC2;
            end
        end

        o_res.frame_command  = n_cmd;
        o_res.frame_sequence = n_seq;
        o_res.frame_len      = n_len;
    end

    // Hold frame state, advance on each stepped item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_HUNT;
            r_crc    <= CRC_INIT;
            r_len    <= '0;
            r_cmd    <= '0;
            r_seq    <= '0;
            r_crc_lo <= '0;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_len    <= n_len;
            r_cmd    <= n_cmd;
            r_seq    <= n_seq;
            r_crc_lo <= n_crc_lo;
        end
    end

    // Payload items only come from the body of a frame
    a_payload_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind == KIND_PAYLOAD) |-> (r_pos >= POS_BODY))
        else $error("payload item outside frame body");

    // Any verdict sends the receiver back to hunting
    a_verdict_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.valid && o_res.kind != KIND_PAYLOAD) |=> (r_pos == POS_HUNT))
        else $error("verdict did not restart the hunt");

    // Position never runs past the high CRC byte of the current frame
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= w_crc_hi_pos)
        else $error("byte position beyond frame end");

    // Reset always lands in the hunt
    a_reset_hunt: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_pos == POS_HUNT && r_crc == CRC_INIT))
        else $error("reset did not clear frame state");

endmodule
`default_nettype wire

[src/crc_framed_packet_receiver.sv]
// Framed packet receiver. Takes one received byte per item on i_rx, hunts for
// the sync pair A5 5A, then reads length, command and sequence, the payload and
// a little-endian CRC-16/CCITT-FALSE over everything from the sync byte on.
// Each payload byte comes out as a kind 0 item as it arrives; the last CRC byte
// yields kind 1 (good) or kind 2 (CRC mismatch), and a length above max_payload
// yields kind 3 right after the header and restarts the hunt. Other bytes give
// no item. Throughput is one byte per clock unless a low o_res.ready holds the
// full result register; an item passes the input register and then the result
// register. The clock period is set by the byte-wide CRC update and the position
// compare in the parser stage. Write max_payload (reset 89) only while idle.
`default_nettype none
module crc_framed_packet_receiver (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    crcfpr_rx_if.sink       i_rx,
    crcfpr_res_if.source    o_res
);
    import crcfpr_pkg::*;

    logic [7:0]  r_max_payload_val;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;
    t_result     w_res;
    logic        w_out_free;
    logic        w_step;

    // Payload limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload_val <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            r_max_payload_val <= i_cfg_wdata;
        end
    end

    // Step the parser when the result register can take what it makes
    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_step     = r_in_valid && w_out_free;
    assign i_rx.ready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    crcfpr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_byte        (r_in_byte),
        .i_max_payload (r_max_payload_val),
        .o_res         (w_res)
    );

    // Result register: load a new item, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res.valid) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kind           = r_out.kind;
    assign o_res.payload_byte   = r_out.payload_byte;
    assign o_res.payload_index  = r_out.payload_index;
    assign o_res.frame_command  = r_out.frame_command;
    assign o_res.frame_sequence = r_out.frame_sequence;
    assign o_res.frame_len      = r_out.frame_len;
    assign o_res.received_check = r_out.received_check;
    assign o_res.computed_check = r_out.computed_check;

endmodule
`default_nettype wire
